FILE: sv/lcs_pkg.sv
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int PERSON_W = 11;
    localparam int SIZE_W   = 11;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic clear;
        logic wr_en;
    } lcs_store_ctrl_t;

endpackage

FILE: sv/lcs_store.sv
`timescale 1ns / 1ps

module lcs_store
    import lcs_pkg::*;
#(
    parameter int MAX_PEOPLE = 1024,
    localparam int IDX_W = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcs_store_ctrl_t       ctrl,
    input  logic [IDX_W-1:0]      par_raddr,
    output logic [IDX_W-1:0]      par_rdata,
    input  logic [IDX_W-1:0]      par_waddr,
    input  logic [IDX_W-1:0]      par_wdata,
    input  logic [IDX_W-1:0]      size_raddr,
    output logic [SIZE_W-1:0]     size_rdata,
    input  logic [IDX_W-1:0]      size_waddr,
    input  logic [SIZE_W-1:0]     size_wdata,
    output logic                  busy
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PEOPLE - 1);

    logic [IDX_W-1:0]  par_mem  [MAX_PEOPLE];
    logic [SIZE_W-1:0] size_mem [MAX_PEOPLE];

    logic              busy_reg;
    logic [IDX_W-1:0]  sweep_reg;
    logic [IDX_W-1:0]  par_rdata_reg;
    logic [SIZE_W-1:0] size_rdata_reg;

    logic              we;
    logic [IDX_W-1:0]  pw_addr;
    logic [IDX_W-1:0]  pw_data;
    logic [IDX_W-1:0]  sw_addr;
    logic [SIZE_W-1:0] sw_data;

    // clearing pass owns the write ports while busy
    always_comb
    begin
        we      = busy_reg | ctrl.wr_en;
        pw_addr = busy_reg ? sweep_reg : par_waddr;
        pw_data = busy_reg ? sweep_reg : par_wdata;
        sw_addr = busy_reg ? sweep_reg : size_waddr;
        sw_data = busy_reg ? SIZE_W'(1) : size_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (sweep_reg == LAST_IDX)
            begin
                busy_reg <= 1'b0;
            end
            sweep_reg <= sweep_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            par_mem[pw_addr]  <= pw_data;
            size_mem[sw_addr] <= sw_data;
        end
        par_rdata_reg  <= par_mem[par_raddr];
        size_rdata_reg <= size_mem[size_raddr];
    end

    assign par_rdata  = par_rdata_reg;
    assign size_rdata = size_rdata_reg;
    assign busy       = busy_reg;

endmodule

FILE: sv/largest_component_size.sv
// edge beat: walks from the first endpoint and then from the second up to their roots,
//   one cycle per parent hop in the shared parent memory; tree depth stays below log2(n)+1;
//   then reads both root sizes and links the roots, unless both already share a component
// out-of-range edge: ignored; finish beat: result registered in ST_WAIT_OUT once the output is
//   free (the previous result taken), then a clearing pass over all MAX_PEOPLE entries;
//   s_tready returns when that pass ends
// reset and every people_count write run the same clearing pass,
//   during which s_tready stays low
`timescale 1ns / 1ps

module largest_component_size
    import lcs_pkg::*;
#(
    parameter int MAX_PEOPLE = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // first_person, second_person, zero pad
    input  logic                  s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // largest_group, zero pad
    input  logic                  cfg_wr_en,
    input  logic [PERSON_W-1:0]   cfg_wr_data
);

    localparam int IDX_W = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
    localparam int CNT_W = (IDX_W + 1 > PERSON_W) ? IDX_W + 1 : PERSON_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PEOPLE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND_A,
        ST_FIND_B,
        ST_SIZE_A,
        ST_LINK,
        ST_WAIT_OUT,
        ST_CLEAR
    } state_t;

    state_t              state_reg;
    logic [PERSON_W-1:0] count_reg;
    logic [SIZE_W-1:0]   best_reg;
    logic [IDX_W-1:0]    v_reg;
    logic [IDX_W-1:0]    b_idx_reg;
    logic [IDX_W-1:0]    ra_reg;
    logic [IDX_W-1:0]    rb_reg;
    logic [SIZE_W-1:0]   sa_reg;
    logic                m_tvalid_reg;
    logic [SIZE_W-1:0]   m_data_reg;

    lcs_store_ctrl_t     ctrl;
    logic [IDX_W-1:0]    par_raddr;
    logic [IDX_W-1:0]    par_rdata;
    logic [IDX_W-1:0]    par_waddr;
    logic [IDX_W-1:0]    par_wdata;
    logic [IDX_W-1:0]    size_raddr;
    logic [SIZE_W-1:0]   size_rdata;
    logic [IDX_W-1:0]    size_waddr;
    logic [SIZE_W-1:0]   size_wdata;
    logic                busy;

    logic [CNT_W-1:0]    cnt_ext;
    logic [CNT_W-1:0]    n_cnt;
    logic [CNT_W-1:0]    a_ext;
    logic [CNT_W-1:0]    b_ext;
    logic [CNT_W-1:0]    a_m1;
    logic [CNT_W-1:0]    b_m1;
    logic                edge_ok;
    logic                in_beat;
    logic                out_free;
    logic                at_root;
    logic [SIZE_W:0]     merged_wide;
    logic [SIZE_W-1:0]   merged;
    logic                b_bigger;

    always_comb
    begin
        cnt_ext  = CNT_W'(count_reg);
        n_cnt    = (cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext;
        a_ext    = CNT_W'(s_tdata[PERSON_W-1:0]);
        b_ext    = CNT_W'(s_tdata[2*PERSON_W-1:PERSON_W]);
        a_m1     = a_ext - CNT_W'(1);
        b_m1     = b_ext - CNT_W'(1);
        edge_ok  = (a_ext != '0) && (b_ext != '0) && (a_ext <= n_cnt) && (b_ext <= n_cnt);
        in_beat  = s_tvalid && s_tready;
        out_free = !m_tvalid_reg || m_tready;
        at_root  = (par_rdata == v_reg);
        merged_wide = {1'b0, sa_reg} + {1'b0, size_rdata};
        merged      = merged_wide[SIZE_W-1:0];
        b_bigger    = (size_rdata > sa_reg);
    end

    always_comb
    begin
        par_raddr  = par_rdata;
        size_raddr = ra_reg;
        par_waddr  = b_bigger ? ra_reg : rb_reg;
        par_wdata  = b_bigger ? rb_reg : ra_reg;
        size_waddr = b_bigger ? rb_reg : ra_reg;
        size_wdata = merged;
        ctrl.wr_en = (state_reg == ST_LINK);
        ctrl.clear = cfg_wr_en || ((state_reg == ST_WAIT_OUT) && out_free);
        case (state_reg)
            ST_IDLE:
            begin
                par_raddr = a_m1[IDX_W-1:0];
            end
            ST_FIND_A:
            begin
                par_raddr = at_root ? b_idx_reg : par_rdata;
            end
            ST_SIZE_A:
            begin
                size_raddr = rb_reg;
            end
            default:
            begin
                par_raddr = par_rdata;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            count_reg    <= PERSON_W'(1);
            best_reg     <= SIZE_W'(1);
            v_reg        <= '0;
            b_idx_reg    <= '0;
            ra_reg       <= '0;
            rb_reg       <= '0;
            sa_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (cfg_wr_en || (state_reg != ST_WAIT_OUT)))
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                // new vertex count starts a fresh graph
                count_reg <= cfg_wr_data;
                best_reg  <= (cfg_wr_data != '0) ? SIZE_W'(1) : '0;
                state_reg <= ST_CLEAR;
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (in_beat)
                        begin
                            if (s_tuser)
                            begin
                                state_reg <= ST_WAIT_OUT;
                            end
                            else if (edge_ok)
                            begin
                                v_reg     <= a_m1[IDX_W-1:0];
                                b_idx_reg <= b_m1[IDX_W-1:0];
                                state_reg <= ST_FIND_A;
                            end
                        end
                    end
                    ST_FIND_A:
                    begin
                        if (at_root)
                        begin
                            ra_reg    <= v_reg;
                            v_reg     <= b_idx_reg;
                            state_reg <= ST_FIND_B;
                        end
                        else
                        begin
                            v_reg <= par_rdata;
                        end
                    end
                    ST_FIND_B:
                    begin
                        if (at_root)
                        begin
                            rb_reg    <= v_reg;
                            state_reg <= (v_reg == ra_reg) ? ST_IDLE : ST_SIZE_A;
                        end
                        else
                        begin
                            v_reg <= par_rdata;
                        end
                    end
                    ST_SIZE_A:
                    begin
                        sa_reg    <= size_rdata;
                        state_reg <= ST_LINK;
                    end
                    ST_LINK:
                    begin
                        if (merged > best_reg)
                        begin
                            best_reg <= merged;
                        end
                        state_reg <= ST_IDLE;
                    end
                    ST_WAIT_OUT:
                    begin
                        if (out_free)
                        begin
                            m_tvalid_reg <= 1'b1;
                            m_data_reg   <= best_reg;
                            best_reg     <= (n_cnt != '0) ? SIZE_W'(1) : '0;
                            state_reg    <= ST_CLEAR;
                        end
                    end
                    ST_CLEAR:
                    begin
                        if (!busy)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    lcs_store #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .par_raddr  (par_raddr),
        .par_rdata  (par_rdata),
        .par_waddr  (par_waddr),
        .par_wdata  (par_wdata),
        .size_raddr (size_raddr),
        .size_rdata (size_rdata),
        .size_waddr (size_waddr),
        .size_wdata (size_wdata),
        .busy       (busy)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(m_data_reg);

    // no beat taken while the store is being cleared
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && busy))
        else $error("input beat possible during clearing pass");

    // best size never exceeds the vertex count
    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(best_reg) <= n_cnt)
        else $error("best size above vertex count");

    // roots being linked are distinct
    a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK) |-> (ra_reg != rb_reg))
        else $error("link of a root to itself");

    // a finish beat always leads to the result stage
    a_finish_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tuser && !cfg_wr_en) |=> (state_reg == ST_WAIT_OUT))
        else $error("finish beat lost");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lcs_pkg::*;

    localparam int MAX_PEOPLE  = 1024;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int PHASE_ITEMS = 215;

    typedef enum logic
    {
        MODE_EDGE   = 1'b0,
        MODE_FINISH = 1'b1
    } item_mode_t;

    typedef struct packed
    {
        item_mode_t           mode;
        logic [PERSON_W-1:0]  first_person;
        logic [PERSON_W-1:0]  second_person;
    } graph_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [PERSON_W-1:0]   cfg_wr_data = '0;

    // graph store as the block should hold it
    logic [PERSON_W-1:0]   vertex_count;
    logic [9:0]            parent_of [MAX_PEOPLE];
    logic [SIZE_W-1:0]     size_of [MAX_PEOPLE];
    logic [SIZE_W-1:0]     best_group;

    graph_item_t           pending_items [$];
    logic [SIZE_W-1:0]     expected_groups [$];

    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    gap_level = 0;
    int                    stall_level = 0;
    int                    burst_left;
    int                    gap_left;
    logic [15:0]           stall_bits;
    logic [3:0]            stall_phase;

    largest_component_size #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic logic [PERSON_W-1:0] vertex_limit();
        return (vertex_count > MAX_PEOPLE) ? PERSON_W'(MAX_PEOPLE) : vertex_count;
    endfunction

    function automatic void clear_groups();
        for (int i = 0; i < MAX_PEOPLE; i++)
        begin
            parent_of[i] = 10'(i);
            size_of[i]   = SIZE_W'(1);
        end
        best_group = (vertex_limit() > 0) ? SIZE_W'(1) : SIZE_W'(0);
    endfunction

    function automatic logic [9:0] root_of(input logic [9:0] start);
        logic [9:0] v;
        logic [9:0] up;
        v = start;
        while (parent_of[v] != v)
        begin
            up = parent_of[v];
            parent_of[v] = parent_of[up];
            v = up;
        end
        return v;
    endfunction

    function automatic void apply_item(input graph_item_t it);
        logic [PERSON_W-1:0] n;
        logic [9:0]          ra;
        logic [9:0]          rb;
        logic [SIZE_W-1:0]   merged;
        n = vertex_limit();
        if (it.mode == MODE_FINISH)
        begin
            expected_groups.push_back(best_group);
            clear_groups();
            return;
        end
        if (it.first_person == 0 || it.second_person == 0 ||
            it.first_person > n || it.second_person > n)
            return;
        ra = root_of(10'(it.first_person - 1));
        rb = root_of(10'(it.second_person - 1));
        if (ra == rb)
            return;
        merged = size_of[ra] + size_of[rb];
        // ties link the second root under the first
        if (size_of[rb] > size_of[ra])
        begin
            parent_of[ra] = rb;
            size_of[rb]   = merged;
        end
        else
        begin
            parent_of[rb] = ra;
            size_of[ra]   = merged;
        end
        if (merged > best_group)
            best_group = merged;
    endfunction

    function automatic void push_item(input item_mode_t mode, input logic [PERSON_W-1:0] a,
                                      input logic [PERSON_W-1:0] b);
        graph_item_t it;
        it.mode          = mode;
        it.first_person  = a;
        it.second_person = b;
        pending_items.push_back(it);
    endfunction

    function automatic void flag_error(input string what, input logic [SIZE_W-1:0] want,
                                       input logic [SIZE_W-1:0] got);
        error_count++;
        if (error_count <= 10)
            $display("%s: expected %0d, got %0d", what, want, got);
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_groups.size() != 0)
            @(negedge clk);
    endtask

    // the block may still be clearing its store after the last result
    task automatic write_count(input logic [PERSON_W-1:0] value);
        wait_drained();
        repeat (MAX_PEOPLE + 64) @(posedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        vertex_count = value;
        clear_groups();
        @(negedge clk);
    endtask

    // sender: bursts with gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_item(pending_items.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    case (gap_level)
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(0, 3);
                        default: gap_left = $urandom_range(0, 30);
                    endcase
                end
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the beat until taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_items[0].mode;
                s_tdata  <= {2'b00, pending_items[0].second_person,
                             pending_items[0].first_person};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern reloaded each time the 4-bit phase counter wraps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_bits  = '0;
            stall_phase = '0;
        end
        else
        begin
            if (stall_phase == 0)
            begin
                case (stall_level)
                    0:       stall_bits = '1;
                    1:       stall_bits = 16'($urandom | $urandom);
                    default: stall_bits = 16'($urandom & $urandom);
                endcase
            end
            m_tready    <= stall_bits[stall_phase];
            stall_phase = stall_phase + 4'd1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_groups.size() == 0)
                flag_error("unexpected result", '0, m_tdata[SIZE_W-1:0]);
            else if (m_tdata[SIZE_W-1:0] !== expected_groups[0])
                flag_error("largest_group mismatch", expected_groups.pop_front(),
                           m_tdata[SIZE_W-1:0]);
            else
                void'(expected_groups.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        logic [PERSON_W-1:0] phase_counts [8];
        logic [PERSON_W-1:0] n_eff;
        int                  pushed;
        int                  pool;
        int                  offset;
        int                  edges;
        logic [PERSON_W-1:0] a;
        logic [PERSON_W-1:0] b;
        bit                  paused;

        vertex_count = PERSON_W'(1);
        clear_groups();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        gap_level   = 1;
        stall_level = 1;

        // reset count of one: single vertex, self loop, endpoint past the count
        push_item(MODE_FINISH, 11'd0, 11'd0);
        push_item(MODE_EDGE, 11'd1, 11'd1);
        push_item(MODE_EDGE, 11'd1, 11'd2);
        push_item(MODE_FINISH, 11'd2047, 11'd2047);

        // no vertices at all
        write_count(11'd0);
        push_item(MODE_EDGE, 11'd1, 11'd1);
        push_item(MODE_FINISH, 11'd0, 11'd0);

        write_count(11'd1024);
        push_item(MODE_EDGE, 11'd1, 11'd1024);
        push_item(MODE_EDGE, 11'd1024, 11'd512);
        push_item(MODE_EDGE, 11'd0, 11'd5);
        push_item(MODE_EDGE, 11'd1025, 11'd3);
        push_item(MODE_EDGE, 11'd2, 11'd3);
        push_item(MODE_EDGE, 11'd3, 11'd2);
        push_item(MODE_EDGE, 11'd2, 11'd1);
        push_item(MODE_EDGE, 11'd4, 11'd5);
        push_item(MODE_EDGE, 11'd6, 11'd7);
        push_item(MODE_EDGE, 11'd4, 11'd6);
        push_item(MODE_FINISH, 11'd1365, 11'd682);
        push_item(MODE_EDGE, 11'd1023, 11'd1022);
        push_item(MODE_FINISH, 11'd0, 11'd0);

        // count above capacity
        write_count(11'd2047);
        push_item(MODE_EDGE, 11'd1024, 11'd1);
        push_item(MODE_EDGE, 11'd1025, 11'd1);
        push_item(MODE_EDGE, 11'd2047, 11'd2047);
        push_item(MODE_FINISH, 11'd0, 11'd0);

        phase_counts = '{11'd2, 11'd37, 11'd1024, 11'd5, 11'd2047, 11'd300, 11'd16, 11'd64};
        phase_counts[6] = PERSON_W'($urandom_range(3, 100));

        for (int phase = 0; phase < 8; phase++)
        begin
            write_count(phase_counts[phase]);
            gap_level   = (phase == 0) ? 0 : phase % 3;
            stall_level = (phase == 0) ? 0 : (phase + 1) % 3;
            n_eff  = vertex_limit();
            pushed = 0;
            paused = 1'b0;
            while (pushed < PHASE_ITEMS)
            begin
                pool   = $urandom_range(2, (n_eff < 24) ? n_eff : 24);
                offset = $urandom_range(0, n_eff - pool);
                edges  = $urandom_range(0, pool + 4);
                for (int e = 0; e < edges; e++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // noise: any field value, mostly ignored
                        push_item(MODE_EDGE, PERSON_W'($urandom), PERSON_W'($urandom));
                    end
                    else
                    begin
                        a = PERSON_W'(offset + $urandom_range(1, pool));
                        b = PERSON_W'(offset + $urandom_range(1, pool));
                        push_item(MODE_EDGE, a, b);
                        pushed++;
                    end
                end
                push_item(MODE_FINISH, PERSON_W'($urandom), PERSON_W'($urandom));
                pushed++;
                if (phase == 3 && !paused && pushed >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (MAX_PEOPLE + 64) @(posedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/lcs_pkg.sv
sv/lcs_store.sv
sv/largest_component_size.sv
tb/sv/testbench.sv
